// ----- design/crs_pkg.sv -----
// Shared types, constants and register codes of the corner response stream.
package crs_pkg;

	localparam int DEF_MAX_WIDTH = 1024;
	localparam int QUEUE_DEPTH   = 4;

	localparam int PIX_W  = 8;
	localparam int ROW_W  = 12;
	localparam int COL_W  = 10;
	localparam int RESP_W = 53;
	localparam int DIM_W  = 13;
	localparam int CFG_W  = 16;

	localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_RESPONSE_MODE = 2'd2;
	localparam logic [1:0] REG_HARRIS_K      = 2'd3;

	localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
	localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;
	localparam logic        RST_MODE         = 1'b0;
	localparam logic [15:0] RST_HARRIS_K     = 16'd4588;

	localparam logic MODE_HARRIS = 1'b0;
	localparam logic MODE_SHI    = 1'b1;

	localparam logic signed [RESP_W-1:0] MOST_NEG = {1'b1, {(RESP_W-1){1'b0}}};

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [11:0]      height;
		logic             mode;
		logic [15:0]      k;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [ROW_W-1:0] row;
		logic             grad;
		logic             sob;
		logic             rst_max;
		logic [3:0]       mask;
		logic [3:0]       eofm;
	} item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_SHIFT,
		ST_NEXT,
		ST_ACC,
		ST_PROD,
		ST_KMUL,
		ST_RESP,
		ST_SQRT,
		ST_OUT
	} st_t;

endpackage

// ----- design/crs_fifo.sv -----
// Short queue of classified pixel beats between front and back.
module crs_fifo import crs_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = QUEUE_DEPTH,
	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int NW   = $clog2(DEPTH + 1)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         not_empty
);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [NW-1:0] cnt_q;

	assign full      = (cnt_q == NW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/crs_front.sv -----
// Input side: raster position counters and classification of each pixel beat.
module crs_front import crs_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int CW       = $clog2(MAX_WIDTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [PIX_W-1:0] pixel,
	input  logic             q_full,
	output logic             push,
	output item_t            push_item,
	output logic [CW-1:0]    push_col
);

	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [DIM_W-1:0] col_nx, row_nx;
	logic [DIM_W-1:0] rs, cs;
	logic             ex, inner;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;
	assign col_nx   = DIM_W'(col_q) + 1'b1;
	assign row_nx   = DIM_W'(row_q) + 1'b1;

	always_comb begin
		push_item.pixel   = pixel;
		push_item.row     = row_q;
		push_item.grad    = (col_q != '0);
		push_item.sob     = (row_q >= ROW_W'(2)) && (col_q >= CW'(2));
		push_item.rst_max = (row_q == '0) && (col_q == '0);
		push_item.mask    = '0;
		push_item.eofm    = '0;
		rs                = '0;
		cs                = '0;
		ex                = 1'b0;
		inner             = 1'b0;
		for (int k = 0; k < 4; k++) begin
			rs    = DIM_W'(row_q) + DIM_W'(k / 2);
			cs    = DIM_W'(col_q) + DIM_W'(k % 2);
			ex    = ((k / 2 == 0) || (row_nx == DIM_W'(cfg.height)))
				&& ((k % 2 == 0) || (col_nx == cfg.width));
			inner = (rs >= DIM_W'(5)) && (rs <= DIM_W'(cfg.height))
				&& (cs >= DIM_W'(5)) && (cs <= cfg.width);
			push_item.mask[k] = push_item.grad && ex && inner;
			push_item.eofm[k] = (rs == DIM_W'(cfg.height)) && (cs == cfg.width);
		end
	end

	assign push_col = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (col_nx >= cfg.width) begin
				col_q <= '0;
				row_q <= (row_nx >= DIM_W'(cfg.height)) ? '0 : row_nx[ROW_W-1:0];
			end else begin
				col_q <= col_nx[CW-1:0];
			end
		end
	end

endmodule

// ----- design/crs_back.sv -----
// Back side: line buffers, Sobel, window sums, response arithmetic and result beats.
module crs_back import crs_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int CW       = $clog2(MAX_WIDTH)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     q_valid,
	input  item_t                    q_item,
	input  logic [CW-1:0]            q_col,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [RESP_W-1:0] response,
	output logic [ROW_W-1:0]         row,
	output logic [COL_W-1:0]         col,
	output logic                     last_of_run,
	output logic                     end_of_frame,
	output logic signed [RESP_W-1:0] frame_max
);

	st_t st_q, st_d;

	item_t         item_q;
	logic [CW-1:0] ccol_q;
	logic [CW-1:0] gaddr;

	logic [15:0] pmem [MAX_WIDTH];
	logic [87:0] gmem [MAX_WIDTH];
	logic [15:0] prd_q;
	logic [87:0] grd_q;

	logic [7:0]  pw_q   [3][3];
	logic [21:0] gwin_q [5][5];
	logic [7:0]  npw    [3][3];
	logic [21:0] gcol   [5];

	logic [1:0] k_q;
	logic [2:0] wr_q, wc_q;

	logic [25:0]        sxx_q, syy_q;
	logic signed [26:0] sxy_q;
	logic [26:0]        trace_q;
	logic signed [54:0] det_q;
	logic [53:0]        t2_q;
	logic [53:0]        ka_q;
	logic [31:0]        kb_q;
	logic [55:0]        x_q, res_q, bit_q;
	logic signed [RESP_W-1:0] resp_q, rmax_q;

	logic                     oval_q, olast_q, oeof_q;
	logic signed [RESP_W-1:0] oresp_q, omax_q;
	logic [ROW_W-1:0]         orow_q;
	logic [COL_W-1:0]         ocol_q;

	logic pwe, gwe, load, last_cand, lastk;

	logic signed [11:0] gx, gy;
	logic [21:0]        gnew;

	logic [21:0]        entry;
	logic signed [10:0] ex, ey;
	logic signed [21:0] pxx, pyy, pxy;
	logic               incl, acc_end;

	logic [26:0]        trace_d;
	logic [51:0]        m1;
	logic signed [53:0] m2;
	logic [53:0]        t2_d;
	logic [25:0]        diff;
	logic [26:0]        axy;
	logic [55:0]        dd, aa;

	logic [55:0]        kt;
	logic signed [56:0] hr;
	logic [56:0]        rb;
	logic               ge;
	logic [26:0]        sres;

	logic signed [RESP_W-1:0] new_max;
	logic [ROW_W-1:0]         cr;
	logic [DIM_W-1:0]         cc;

	function automatic logic signed [11:0] sob3(logic [7:0] a0, logic [7:0] a1,
		logic [7:0] a2, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
		logic signed [11:0] s;
		s = $signed({4'b0, a0}) + $signed({3'b0, a1, 1'b0}) + $signed({4'b0, a2})
			- $signed({4'b0, b0}) - $signed({3'b0, b1, 1'b0}) - $signed({4'b0, b2});
		return s;
	endfunction

	assign gaddr = ccol_q - 1'b1;

	// pixel window and Sobel
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			npw[i][0] = pw_q[i][1];
			npw[i][1] = pw_q[i][2];
		end
		npw[0][2] = prd_q[7:0];
		npw[1][2] = prd_q[15:8];
		npw[2][2] = item_q.pixel;
		gx = sob3(npw[0][0], npw[0][1], npw[0][2], npw[2][0], npw[2][1], npw[2][2]);
		gy = sob3(npw[0][0], npw[1][0], npw[2][0], npw[0][2], npw[1][2], npw[2][2]);
		gnew = item_q.sob ? {gy[10:0], gx[10:0]} : 22'b0;
		for (int i = 0; i < 4; i++) begin
			gcol[i] = grd_q[i*22 +: 22];
		end
		gcol[4] = gnew;
	end

	// window accumulation
	always_comb begin
		entry   = gwin_q[wr_q][wc_q];
		ex      = $signed(entry[10:0]);
		ey      = $signed(entry[21:11]);
		pxx     = ex * ex;
		pyy     = ey * ey;
		pxy     = ex * ey;
		incl    = (wr_q >= {2'b0, k_q[1]}) && (wc_q >= {2'b0, k_q[0]});
		acc_end = (wr_q == 3'd4) && (wc_q == 3'd4);
	end

	// products
	always_comb begin
		trace_d = {1'b0, sxx_q} + {1'b0, syy_q};
		m1      = sxx_q * syy_q;
		m2      = sxy_q * sxy_q;
		t2_d    = trace_d * trace_d;
		diff    = (sxx_q >= syy_q) ? sxx_q - syy_q : syy_q - sxx_q;
		axy     = sxy_q[26] ? 27'(-sxy_q) : 27'(sxy_q);
		dd      = diff * diff;
		aa      = axy * axy;
	end

	// final arithmetic
	always_comb begin
		kt   = {2'b0, ka_q} + 56'(({1'b0, kb_q} + 33'h8000) >> 16);
		hr   = {{2{det_q[54]}}, det_q} - $signed({1'b0, kt});
		rb   = {1'b0, res_q} + {1'b0, bit_q};
		ge   = ({1'b0, x_q} >= rb);
		sres = trace_q - res_q[26:0];
	end

	always_comb begin
		new_max = (resp_q > rmax_q) ? resp_q : rmax_q;
		cr      = item_q.row - ROW_W'(3) + ROW_W'(k_q[1]);
		cc      = DIM_W'(ccol_q) - DIM_W'(3) + DIM_W'(k_q[0]);
		lastk   = (k_q == 2'd3);
		unique case (k_q)
			2'd0: last_cand = (item_q.mask[3:1] == '0);
			2'd1: last_cand = (item_q.mask[3:2] == '0);
			2'd2: last_cand = !item_q.mask[3];
			2'd3: last_cand = 1'b1;
		endcase
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:  if (q_valid) st_d = ST_READ;
			ST_READ:  st_d = ST_SHIFT;
			ST_SHIFT: st_d = ST_NEXT;
			ST_NEXT: begin
				if (item_q.mask[k_q]) st_d = ST_ACC;
				else if (lastk) st_d = ST_IDLE;
			end
			ST_ACC:   if (acc_end) st_d = ST_PROD;
			ST_PROD:  st_d = (cfg.mode == MODE_SHI) ? ST_SQRT : ST_KMUL;
			ST_KMUL:  st_d = ST_RESP;
			ST_RESP:  st_d = ST_OUT;
			ST_SQRT:  if (bit_q == '0) st_d = ST_OUT;
			ST_OUT: begin
				if (load) st_d = lastk ? ST_IDLE : ST_NEXT;
			end
			default:  st_d = ST_IDLE;
		endcase
	end

	// strobes
	always_comb begin
		pop  = (st_q == ST_IDLE) && q_valid;
		pwe  = (st_q == ST_SHIFT);
		gwe  = (st_q == ST_SHIFT) && item_q.grad;
		load = (st_q == ST_OUT) && (!oval_q || !out_stall);
	end

	// line buffers
	always_ff @(posedge clk) begin
		if (st_q == ST_READ) begin
			prd_q <= pmem[ccol_q];
			grd_q <= gmem[gaddr];
		end
		if (pwe) begin
			pmem[ccol_q] <= {item_q.pixel, prd_q[15:8]};
		end
		if (gwe) begin
			gmem[gaddr] <= {gcol[4], gcol[3], gcol[2], gcol[1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			k_q    <= '0;
			wr_q   <= '0;
			wc_q   <= '0;
			oval_q <= 1'b0;
			rmax_q <= MOST_NEG;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pw_q[i][j] <= '0;
				end
			end
			for (int i = 0; i < 5; i++) begin
				for (int j = 0; j < 5; j++) begin
					gwin_q[i][j] <= '0;
				end
			end
		end else begin
			st_q <= st_d;
			if (pop) begin
				k_q <= '0;
			end
			if (st_q == ST_SHIFT) begin
				pw_q <= npw;
				if (item_q.rst_max) begin
					rmax_q <= MOST_NEG;
				end
				if (item_q.grad) begin
					for (int i = 0; i < 5; i++) begin
						for (int j = 0; j < 4; j++) begin
							gwin_q[i][j] <= gwin_q[i][j+1];
						end
						gwin_q[i][4] <= gcol[i];
					end
				end
			end
			if (st_q == ST_NEXT) begin
				wr_q <= '0;
				wc_q <= '0;
				if (!item_q.mask[k_q] && !lastk) begin
					k_q <= k_q + 1'b1;
				end
			end
			if (st_q == ST_ACC) begin
				if (wc_q == 3'd4) begin
					wc_q <= '0;
					wr_q <= wr_q + 1'b1;
				end else begin
					wc_q <= wc_q + 1'b1;
				end
			end
			if (load) begin
				oval_q <= 1'b1;
				rmax_q <= new_max;
				if (!lastk) begin
					k_q <= k_q + 1'b1;
				end
			end else if (!out_stall) begin
				oval_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= q_item;
			ccol_q <= q_col;
		end
		if (st_q == ST_NEXT) begin
			sxx_q <= '0;
			syy_q <= '0;
			sxy_q <= '0;
		end
		if (st_q == ST_ACC && incl) begin
			sxx_q <= sxx_q + 26'(pxx[20:0]);
			syy_q <= syy_q + 26'(pyy[20:0]);
			sxy_q <= sxy_q + 27'(pxy);
		end
		if (st_q == ST_PROD) begin
			trace_q <= trace_d;
			det_q   <= $signed({3'b0, m1}) - $signed({m2[53], m2});
			t2_q    <= t2_d;
			x_q     <= dd + {aa[53:0], 2'b0};
			res_q   <= '0;
			bit_q   <= 56'd1 << 54;
		end
		if (st_q == ST_KMUL) begin
			ka_q <= cfg.k * t2_q[53:16];
			kb_q <= cfg.k * t2_q[15:0];
		end
		if (st_q == ST_RESP) begin
			resp_q <= hr[RESP_W-1:0];
		end
		if (st_q == ST_SQRT) begin
			if (bit_q == '0) begin
				resp_q <= {27'b0, sres[26:1]};
			end else begin
				if (ge) begin
					x_q   <= x_q - rb[55:0];
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
		end
		if (load) begin
			oresp_q <= resp_q;
			orow_q  <= cr;
			ocol_q  <= cc[COL_W-1:0];
			olast_q <= last_cand;
			oeof_q  <= item_q.eofm[k_q];
			omax_q  <= new_max;
		end
	end

	assign out_valid    = oval_q;
	assign response     = oresp_q;
	assign row          = orow_q;
	assign col          = ocol_q;
	assign last_of_run  = olast_q;
	assign end_of_frame = oeof_q;
	assign frame_max    = omax_q;

endmodule

// ----- design/corner_response_stream_unit.sv -----
// Top level of the corner response stream: configuration registers and block wiring.
//
// Grey pixels enter in raster order on the in channel (in_valid, in_stall, pixel),
// one beat per pixel. Result beats leave on the out channel with the corner
// response of a 5x5 window of 3x3 Sobel gradients, its centre row and column,
// a last_of_run flag on the last beat caused by a pixel, end_of_frame on the
// final interior centre and the running frame maximum.
// Registers must be written by the user through cfg_we, cfg_index and cfg_data only
// while the block idles; the block itself does not enforce this. The front counts
// positions and queues up to four pixel beats; the back sequencer handles one pixel
// at a time: per result, Harris mode runs the window sum, product, scaling and output,
// and Shi-Tomasi mode the window sum plus a 28-step square root.
// Reset clears the counters, the pixel and gradient windows, the running maximum
// and the queue; line buffer contents stay undefined until written.
// A stalled out channel holds its beat; the back then waits and the queue fills,
// after which in_stall rises.
module corner_response_stream_unit import crs_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int CW       = $clog2(MAX_WIDTH)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [PIX_W-1:0]         pixel,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [RESP_W-1:0] response,
	output logic [ROW_W-1:0]         row,
	output logic [COL_W-1:0]         col,
	output logic                     last_of_run,
	output logic                     end_of_frame,
	output logic signed [RESP_W-1:0] frame_max
);

	localparam int QW = $bits(item_t) + CW;

	logic [10:0] width_q;
	logic [11:0] height_q;
	logic        mode_q;
	logic [15:0] k_q;
	cfg_t        cfg;

	logic          q_full, q_push, q_pop, q_valid;
	item_t         push_item, pop_item;
	logic [CW-1:0] push_col, pop_col;
	logic [QW-1:0] pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_FRAME_WIDTH;
			height_q <= RST_FRAME_HEIGHT;
			mode_q   <= RST_MODE;
			k_q      <= RST_HARRIS_K;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:   width_q  <= cfg_data[10:0];
				REG_FRAME_HEIGHT:  height_q <= cfg_data[11:0];
				REG_RESPONSE_MODE: mode_q   <= cfg_data[0];
				REG_HARRIS_K:      k_q      <= cfg_data;
			endcase
		end
	end

	// clamp frame size
	always_comb begin
		if (width_q < 11'd8) begin
			cfg.width = DIM_W'(8);
		end else if (DIM_W'(width_q) > DIM_W'(MAX_WIDTH)) begin
			cfg.width = DIM_W'(MAX_WIDTH);
		end else begin
			cfg.width = DIM_W'(width_q);
		end
		cfg.height = (height_q < 12'd8) ? 12'd8 : height_q;
		cfg.mode   = mode_q;
		cfg.k      = k_q;
	end

	crs_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel     (pixel),
		.q_full    (q_full),
		.push      (q_push),
		.push_item (push_item),
		.push_col  (push_col)
	);

	crs_fifo #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_col, push_item}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.not_empty (q_valid)
	);

	assign pop_item = pop_data[$bits(item_t)-1:0];
	assign pop_col  = pop_data[QW-1:$bits(item_t)];

	crs_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_valid      (q_valid),
		.q_item       (pop_item),
		.q_col        (pop_col),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.response     (response),
		.row          (row),
		.col          (col),
		.last_of_run  (last_of_run),
		.end_of_frame (end_of_frame),
		.frame_max    (frame_max)
	);

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench of corner_response_stream_unit: frames streamed against a predictor.
module testbench;
	import crs_pkg::*;

	typedef struct {
		logic signed [RESP_W-1:0] resp;
		logic [ROW_W-1:0]         row;
		logic [COL_W-1:0]         col;
		logic                     last;
		logic                     eof;
		logic signed [RESP_W-1:0] fmax;
	} corner_t;

	typedef struct {
		int unsigned w;
		int unsigned h;
		logic        mode;
		int unsigned k;
		int          kind;
		bit          zero;
	} frame_spec_t;

	localparam int MW = DEF_MAX_WIDTH;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [PIX_W-1:0] pixel = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [RESP_W-1:0] response;
	logic [ROW_W-1:0] row;
	logic [COL_W-1:0] col;
	logic last_of_run;
	logic end_of_frame;
	logic signed [RESP_W-1:0] frame_max;

	corner_response_stream_unit DUT (.*);

	always #5 clk = ~clk;

	logic [7:0]  pix_lines [0:2*MW-1];
	logic [21:0] grad_lines [0:4*MW-1];
	logic [21:0] grad_win [0:24];
	logic [7:0]  pix_win [0:8];
	int unsigned row_cnt, col_cnt;
	longint      run_max;
	int unsigned cfg_width, cfg_height, cfg_k;
	logic        cfg_mode;

	corner_t corners_due[$];
	int errors = 0;
	int unsigned sent_cnt = 0;
	bit quiet = 0;
	bit expect_zero = 0;
	bit hold_req = 0;

	task automatic report(string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint window_response(int dr, int dc);
		longint sxx, syy, sxy, gx, gy, det;
		longint unsigned trace, t2, kk, kt, diff, axy, s;
		logic signed [10:0] a, b;
		sxx = 0;
		syy = 0;
		sxy = 0;
		for (int i = 0; i < 5; i++)
			for (int j = 0; j < 5; j++)
				if (i + dr <= 4 && j + dc <= 4) begin
					a = grad_win[(i + dr) * 5 + j + dc][10:0];
					b = grad_win[(i + dr) * 5 + j + dc][21:11];
					gx = a;
					gy = b;
					sxx += gx * gx;
					syy += gy * gy;
					sxy += gx * gy;
				end
		det = sxx * syy - sxy * sxy;
		trace = sxx + syy;
		if (cfg_mode == MODE_HARRIS) begin
			t2 = trace * trace;
			kk = cfg_k;
			kt = kk * (t2 >> 16) + ((kk * (t2 & 64'hFFFF) + 64'h8000) >> 16);
			return det - longint'(kt);
		end
		diff = (sxx >= syy) ? sxx - syy : syy - sxx;
		axy = (sxy < 0) ? -sxy : sxy;
		s = int_sqrt(diff * diff + 4 * axy * axy);
		return longint'((trace - s) >> 1);
	endfunction

	function automatic int unsigned eff_width();
		return (cfg_width < 8) ? 8 : (cfg_width > MW) ? MW : cfg_width;
	endfunction

	function automatic int unsigned eff_height();
		return (cfg_height < 8) ? 8 : (cfg_height > 4095) ? 4095 : cfg_height;
	endfunction

	task automatic predict_corners(logic [7:0] p);
		int unsigned w, h, c, r;
		logic [7:0] top, mid;
		int gx, gy, cr, cc;
		logic [21:0] g;
		logic [21:0] colv [0:4];
		longint rv;
		corner_t batch[$];
		corner_t e;
		w = eff_width();
		h = eff_height();
		c = col_cnt % MW;
		r = row_cnt;
		if (r == 0 && c == 0)
			run_max = -(longint'(1) << 52);
		top = pix_lines[c];
		mid = pix_lines[MW + c];
		pix_lines[c] = mid;
		pix_lines[MW + c] = p;
		for (int i = 0; i < 3; i++) begin
			pix_win[i*3] = pix_win[i*3+1];
			pix_win[i*3+1] = pix_win[i*3+2];
		end
		pix_win[2] = top;
		pix_win[5] = mid;
		pix_win[8] = p;
		if (c >= 1) begin
			gx = 0;
			gy = 0;
			if (r >= 2 && c >= 2)
				for (int i = 0; i < 3; i++) begin
					gx += (i == 1 ? 2 : 1) * (int'(pix_win[i]) - int'(pix_win[6+i]));
					gy += (i == 1 ? 2 : 1) * (int'(pix_win[i*3]) - int'(pix_win[i*3+2]));
				end
			g = {gy[10:0], gx[10:0]};
			for (int i = 0; i < 4; i++)
				colv[i] = grad_lines[i*MW + c - 1];
			colv[4] = g;
			for (int i = 0; i < 4; i++)
				grad_lines[i*MW + c - 1] = colv[i+1];
			for (int i = 0; i < 5; i++) begin
				for (int j = 0; j < 4; j++)
					grad_win[i*5+j] = grad_win[i*5+j+1];
				grad_win[i*5+4] = colv[i];
			end
			for (int dr = 0; dr <= ((r == h - 1) ? 1 : 0); dr++)
				for (int dc = 0; dc <= ((c == w - 1) ? 1 : 0); dc++) begin
					cr = int'(r) - 3 + dr;
					cc = int'(c) - 3 + dc;
					if (cr >= 2 && cr <= int'(h) - 3 && cc >= 2 && cc <= int'(w) - 3) begin
						rv = window_response(dr, dc);
						if (rv > run_max)
							run_max = rv;
						e.resp = rv[RESP_W-1:0];
						e.row = cr[ROW_W-1:0];
						e.col = cc[COL_W-1:0];
						e.last = 1'b0;
						e.eof = (cr == int'(h) - 3 && cc == int'(w) - 3);
						e.fmax = run_max[RESP_W-1:0];
						batch = {batch, e};
					end
				end
			if (batch.size() > 0)
				batch[batch.size()-1].last = 1'b1;
			foreach (batch[i])
				corners_due = {corners_due, batch[i]};
		end
		if (col_cnt + 1 >= w) begin
			col_cnt = 0;
			row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
		end else begin
			col_cnt++;
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH: cfg_width = data[10:0];
			REG_FRAME_HEIGHT: cfg_height = data[11:0];
			REG_RESPONSE_MODE: cfg_mode = data[0];
			default: cfg_k = data;
		endcase
	endtask

	task automatic drain();
		while (corners_due.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic send_pixel(logic [7:0] p);
		if (sent_cnt >= 210)
			quiet = 1;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= p;
		do
			@(posedge clk);
		while (in_stall);
		sent_cnt++;
		predict_corners(p);
	endtask

	function automatic logic [7:0] pick_pixel(int kind, int unsigned r, int unsigned c);
		case (kind)
			0: return 8'd0;
			1: return 8'd255;
			2: return ((r + c) & 1) ? 8'd255 : 8'd0;
			4: return ($urandom_range(0, 3) == 0) ? {8{1'($urandom_range(0, 1))}}
				: 8'($urandom_range(0, 255));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic run_frame(frame_spec_t f);
		int unsigned ew, eh;
		drain();
		expect_zero = f.zero;
		write_reg(REG_FRAME_WIDTH, f.w[CFG_W-1:0]);
		write_reg(REG_FRAME_HEIGHT, f.h[CFG_W-1:0]);
		write_reg(REG_RESPONSE_MODE, {15'd0, f.mode});
		write_reg(REG_HARRIS_K, f.k[CFG_W-1:0]);
		ew = eff_width();
		eh = eff_height();
		for (int unsigned r = 0; r < eh; r++)
			for (int unsigned c = 0; c < ew; c++)
				send_pixel(pick_pixel(f.kind, r, c));
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		corner_t e;
		if (out_valid && !out_stall) begin
			if (corners_due.size() == 0) begin
				report($sformatf("unexpected beat row %0d col %0d", row, col));
			end else begin
				e = corners_due.pop_front();
				if (response !== e.resp)
					report($sformatf("response %0d want %0d at %0d,%0d",
						response, e.resp, e.row, e.col));
				if (row !== e.row || col !== e.col)
					report($sformatf("position %0d,%0d want %0d,%0d", row, col, e.row, e.col));
				if (last_of_run !== e.last)
					report($sformatf("last_of_run %b at %0d,%0d", last_of_run, e.row, e.col));
				if (end_of_frame !== e.eof)
					report($sformatf("end_of_frame %b at %0d,%0d", end_of_frame, e.row, e.col));
				if (frame_max !== e.fmax)
					report($sformatf("frame_max %0d want %0d", frame_max, e.fmax));
				if (expect_zero && (response !== '0 || frame_max !== '0))
					report($sformatf("flat frame gave nonzero response at %0d,%0d", row, col));
			end
		end
	end

	initial begin
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (800) @(posedge clk);
				hold_req = 0;
			end else if (quiet || $urandom_range(0, 2) != 0) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
	end

	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end

	frame_spec_t directed [0:2] = '{
		'{8, 8, MODE_HARRIS, 4588, 0, 1},
		'{3, 16'hF003, MODE_SHI, 65535, 2, 0},
		'{8, 8, MODE_HARRIS, 65535, 4, 0}
	};

	initial begin
		frame_spec_t f;
		cfg_width = RST_FRAME_WIDTH;
		cfg_height = RST_FRAME_HEIGHT;
		cfg_mode = RST_MODE;
		cfg_k = RST_HARRIS_K;
		row_cnt = 0;
		col_cnt = 0;
		run_max = -(longint'(1) << 52);
		for (int i = 0; i < 2*MW; i++) pix_lines[i] = '0;
		for (int i = 0; i < 4*MW; i++) grad_lines[i] = '0;
		for (int i = 0; i < 25; i++) grad_win[i] = '0;
		for (int i = 0; i < 9; i++) pix_win[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			if (i == 1)
				hold_req = 1;
			run_frame(directed[i]);
		end
		while (sent_cnt < 240) begin
			f.w = $urandom_range(8, 12);
			f.h = $urandom_range(8, 9);
			f.mode = 1'($urandom_range(0, 1));
			f.k = $urandom_range(0, 65535);
			f.kind = ($urandom_range(0, 3) == 0) ? 4 : 3;
			f.zero = 0;
			run_frame(f);
		end
		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
